FILE: rtl/sqd_pkg.sv
// Shared types and constants of the squared distance engine.
package sqd_pkg;

   localparam int ELEM_W   = 8;
   localparam int LENGTH_W = 11;
   localparam int DIST_W   = 26;
   localparam int COUNT_W  = 16;
   localparam int SUM_W    = 27;
   localparam int SQ_W     = 16;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd64;

   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;
   localparam logic [ADDR_W-3:0] REG_VECTOR_LENGTH = 1'b0;

   localparam logic MODE_PROBE = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int QCOUNT_W = 3;

   typedef struct packed {
      logic              mode;
      logic [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0]  squared_distance;
      logic [COUNT_W-1:0] point_number;
   } rsp_type;

   typedef struct packed {
      logic [ELEM_W-1:0]  element;
      logic [ELEM_W-1:0]  probe;
      logic               first;
      logic               last;
      logic [COUNT_W-1:0] point_number;
   } work_type;

endpackage

FILE: rtl/sqd_front.sv
// Front end: accepts beats, keeps the element indexes and the probe store.
module sqd_front #(
   parameter int MAX_DIM = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sqd_pkg::req_type              req_data,
   input  logic [sqd_pkg::LENGTH_W-1:0]  vector_length,
   input  logic [sqd_pkg::QCOUNT_W-1:0]  q_count,
   output logic                          push,
   output sqd_pkg::work_type             work
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CMP_W = (IDX_W + 1 > sqd_pkg::LENGTH_W) ? IDX_W + 1 : sqd_pkg::LENGTH_W;
   localparam int USE_W = sqd_pkg::QCOUNT_W + 1;

   logic [sqd_pkg::ELEM_W-1:0] probe_mem [0:MAX_DIM-1];

   logic [IDX_W-1:0]            pw_idx_ff, pw_idx_in;
   logic [IDX_W-1:0]            pe_idx_ff, pe_idx_in;
   logic [sqd_pkg::COUNT_W-1:0] pcount_ff, pcount_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic [sqd_pkg::ELEM_W-1:0]  s1_elem_ff;
   logic                        s1_first_ff;
   logic                        s1_last_ff;
   logic [sqd_pkg::COUNT_W-1:0] s1_pnum_ff;
   logic [sqd_pkg::ELEM_W-1:0]  rd_ff;

   logic [CMP_W-1:0] len_ext, max_ext, dim;
   logic [CMP_W-1:0] pw_nxt, pe_nxt;
   logic             pw_wrap, pe_wrap;
   logic [USE_W-1:0] used;
   logic             accept, is_probe;

   always_comb begin
      len_ext = CMP_W'(vector_length);
      max_ext = CMP_W'(MAX_DIM);
      if (len_ext == '0) begin
         dim = CMP_W'(1);
      end else if (len_ext > max_ext) begin
         dim = max_ext;
      end else begin
         dim = len_ext;
      end
   end

   assign pw_nxt  = CMP_W'(pw_idx_ff) + CMP_W'(1);
   assign pe_nxt  = CMP_W'(pe_idx_ff) + CMP_W'(1);
   assign pw_wrap = pw_nxt >= dim;
   assign pe_wrap = pe_nxt >= dim;

   // One queue slot is held back for the beat that is still in the read stage.
   assign used      = USE_W'(q_count) + USE_W'(s1_valid_ff);
   assign req_stall = used >= USE_W'(sqd_pkg::QDEPTH);
   assign accept    = req_valid && !req_stall;
   assign is_probe  = req_data.mode == sqd_pkg::MODE_PROBE;

   always_comb begin
      pw_idx_in   = pw_idx_ff;
      pe_idx_in   = pe_idx_ff;
      pcount_in   = pcount_ff;
      s1_valid_in = 1'b0;
      if (accept) begin
         if (is_probe) begin
            pw_idx_in = pw_wrap ? '0 : pw_nxt[IDX_W-1:0];
            pe_idx_in = '0;
            pcount_in = '0;
         end else begin
            pe_idx_in   = pe_wrap ? '0 : pe_nxt[IDX_W-1:0];
            pcount_in   = pe_wrap ? pcount_ff + sqd_pkg::COUNT_W'(1) : pcount_ff;
            s1_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_idx_ff   <= '0;
         pe_idx_ff   <= '0;
         pcount_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pw_idx_ff   <= pw_idx_in;
         pe_idx_ff   <= pe_idx_in;
         pcount_ff   <= pcount_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_elem_ff  <= req_data.element;
         s1_first_ff <= pe_idx_ff == '0;
         s1_last_ff  <= pe_wrap;
         s1_pnum_ff  <= pcount_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_probe) begin
         probe_mem[pw_idx_ff] <= req_data.element;
      end
      rd_ff <= probe_mem[pe_idx_ff];
   end

   assign push              = s1_valid_ff;
   assign work.element      = s1_elem_ff;
   assign work.probe        = rd_ff;
   assign work.first        = s1_first_ff;
   assign work.last         = s1_last_ff;
   assign work.point_number = s1_pnum_ff;

   a_probe_restarts_point: assert property (@(posedge clock) disable iff (reset)
      (accept && is_probe) |=> (pe_idx_ff == '0 && pcount_ff == '0 && !s1_valid_ff))
      else $error("probe load did not restart the point");

endmodule

FILE: rtl/sqd_queue.sv
// Short queue of point elements between the front end and the back end.
module sqd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  sqd_pkg::work_type            push_data,
   input  logic                         pop,
   output sqd_pkg::work_type            head,
   output logic                         not_empty,
   output logic [sqd_pkg::QCOUNT_W-1:0] count
);

   sqd_pkg::work_type entry_ff [0:sqd_pkg::QDEPTH-1];

   logic [sqd_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sqd_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sqd_pkg::QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = pop  ? rd_ptr_ff + sqd_pkg::QPTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_ff + sqd_pkg::QPTR_W'(1) : wr_ptr_ff;
      count_in  = count_ff + sqd_pkg::QCOUNT_W'(push) - sqd_pkg::QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < sqd_pkg::QCOUNT_W'(sqd_pkg::QDEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

FILE: rtl/sqd_back.sv
// Back end: squares each difference, accumulates a point and holds the result.
module sqd_back (
   input  logic              clock,
   input  logic              reset,
   input  sqd_pkg::work_type head,
   input  logic              not_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sqd_pkg::rsp_type  rsp_data
);

   logic                         b1_valid_ff, b1_valid_in;
   logic [sqd_pkg::SQ_W-1:0]     b1_sq_ff;
   logic                         b1_first_ff;
   logic                         b1_last_ff;
   logic [sqd_pkg::COUNT_W-1:0]  b1_pnum_ff;
   logic [sqd_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   sqd_pkg::rsp_type             rsp_data_ff;

   logic [sqd_pkg::ELEM_W:0]     diff;
   logic [sqd_pkg::ELEM_W:0]     neg_diff;
   logic [sqd_pkg::ELEM_W-1:0]   abs_diff;
   logic [sqd_pkg::SQ_W-1:0]     sq;
   logic                         blocked, advance, finish;

   assign diff     = {1'b0, head.element} - {1'b0, head.probe};
   assign neg_diff = '0 - diff;
   assign abs_diff = diff[sqd_pkg::ELEM_W] ? neg_diff[sqd_pkg::ELEM_W-1:0]
                                           : diff[sqd_pkg::ELEM_W-1:0];
   assign sq       = sqd_pkg::SQ_W'(abs_diff) * sqd_pkg::SQ_W'(abs_diff);

   // Only a finishing element needs the result register free; others keep flowing.
   assign blocked = b1_valid_ff && b1_last_ff && rsp_valid_ff && rsp_stall;
   assign advance = !blocked;
   assign pop     = not_empty && advance;
   assign finish  = b1_valid_ff && b1_last_ff && !blocked;
   assign sum_in  = (b1_first_ff ? '0 : sum_ff) + sqd_pkg::SUM_W'(b1_sq_ff);

   always_comb begin
      b1_valid_in  = advance ? not_empty : b1_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_sq_ff    <= sq;
         b1_first_ff <= head.first;
         b1_last_ff  <= head.last;
         b1_pnum_ff  <= head.point_number;
      end
      if (b1_valid_ff && !blocked) begin
         sum_ff <= sum_in;
      end
      if (finish) begin
         rsp_data_ff.squared_distance <= sum_in[sqd_pkg::DIST_W-1:0];
         rsp_data_ff.point_number     <= b1_pnum_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_blocked_holds: assert property (@(posedge clock) disable iff (reset)
      blocked |=> (b1_valid_ff && b1_last_ff && $stable(b1_sq_ff) && $stable(b1_pnum_ff)))
      else $error("finishing element lost while the result was stalled");

endmodule

FILE: rtl/squared_distance_engine.sv
// Squared distance engine: top level with the register port and the two halves.
//
// Mode-0 beats load the probe vector element by element; mode-1 beats carry the
// elements of a point, and after vector_length of them (clamped to 1..MAX_DIM)
// one result beat gives the exact squared Euclidean distance and the point's
// number since the last probe load. The block takes one beat per clock cycle
// while req_stall is low; the probe store is written by a probe beat and read
// by a point beat in the same front stage. The edge that accepts the point's
// last element reads the probe, and the queue, the squaring stage and the
// accumulate stage into the result register follow. A four-entry queue lets
// the front end keep accepting while a result waits; req_stall rises once the
// queue and the read stage together hold four beats. The probe store is not
// cleared at reset, so a point may be compared only against written probe
// entries. vector_length may be changed only while the block is idle.
module squared_distance_engine #(
   parameter int MAX_DIM = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sqd_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sqd_pkg::rsp_type             rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sqd_pkg::ADDR_W-1:0]   paddr,
   input  logic [sqd_pkg::DATA_W-1:0]   pwdata,
   output logic [sqd_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   logic [sqd_pkg::LENGTH_W-1:0] vector_length_ff, vector_length_in;
   logic [sqd_pkg::ADDR_W-3:0]   reg_index;
   logic                         reg_write;

   logic                         q_push;
   sqd_pkg::work_type            q_in;
   logic                         q_pop;
   sqd_pkg::work_type            q_head;
   logic                         q_not_empty;
   logic [sqd_pkg::QCOUNT_W-1:0] q_count;

   assign pready    = 1'b1;
   assign reg_index = paddr[sqd_pkg::ADDR_W-1:2];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      vector_length_in = vector_length_ff;
      if (reg_write && reg_index == sqd_pkg::REG_VECTOR_LENGTH) begin
         vector_length_in = pwdata[sqd_pkg::LENGTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= sqd_pkg::LENGTH_RESET;
      end else begin
         vector_length_ff <= vector_length_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == sqd_pkg::REG_VECTOR_LENGTH) begin
         prdata = sqd_pkg::DATA_W'(vector_length_ff);
      end
   end

   sqd_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .vector_length (vector_length_ff),
      .q_count       (q_count),
      .push          (q_push),
      .work          (q_in)
   );

   sqd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   sqd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
